// ----- rtl/core/rau_pkg.sv -----
// rau_pkg: shared types, codes and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  localparam int FIELD_W       = 32;
  localparam int VALUE_W_DEF   = 32;

  localparam logic [2:0] FN_ADD   = 3'd0;
  localparam logic [2:0] FN_SUB   = 3'd1;
  localparam logic [2:0] FN_MUL   = 3'd2;
  localparam logic [2:0] FN_DIV   = 3'd3;
  localparam logic [2:0] FN_NEG   = 3'd4;
  localparam logic [2:0] FN_HALVE = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]                 func;
    logic signed [FIELD_W-1:0]  a_num;
    logic [FIELD_W-1:0]         a_den;
    logic signed [FIELD_W-1:0]  b_num;
    logic [FIELD_W-1:0]         b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  res_num;
    logic [FIELD_W-1:0]         res_den;
    logic [1:0]                 status;
  } out_item_t;

  typedef enum logic [1:0] {RK_NORMAL, RK_ZERO, RK_DIV0} kind_t;

  typedef enum logic [1:0] {MS_AM_B, MS_AD_BM, MS_AD_BD} mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_MUL0, S_MUL1, S_MUL2, S_FORM, S_GCD,
    S_DIVN_INIT, S_DIVN, S_DIVD_INIT, S_DIVD, S_STORE, S_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     gcd_step;
    logic     div_init;
    logic     div_den;
    logic     div_step;
    logic     q_store_num;
    logic     q_store_den;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic use_mul;
    logic gcd_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/rau_ctrl.sv -----
// rau_ctrl: sequencing state machine for the rational arithmetic unit.
// Depends on rau_pkg.
module rau_ctrl #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_W_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  localparam int N  = 2 * VALUE_WIDTH + 1;
  localparam int KW = $clog2(N + 1);

  rau_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]   dc_r, dc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
      dc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dc_r    <= dc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dc_nxt    = dc_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rau_pkg::S_CLASS;
        end
      end
      rau_pkg::S_CLASS: begin
        if (sts.early) state_nxt = rau_pkg::S_FIN;
        else if (sts.use_mul) state_nxt = rau_pkg::S_MUL0;
        else state_nxt = rau_pkg::S_FORM;
      end
      rau_pkg::S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_AM_B;
        state_nxt   = rau_pkg::S_MUL1;
      end
      rau_pkg::S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_AD_BM;
        state_nxt   = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_AD_BD;
        state_nxt   = rau_pkg::S_FORM;
      end
      rau_pkg::S_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = rau_pkg::S_GCD;
      end
      rau_pkg::S_GCD: begin
        if (sts.early) state_nxt = rau_pkg::S_FIN;
        else begin
          cmd.gcd_step = 1'b1;
          if (sts.gcd_done) state_nxt = rau_pkg::S_DIVN_INIT;
        end
      end
      rau_pkg::S_DIVN_INIT: begin
        cmd.div_init = 1'b1;
        dc_nxt       = '0;
        state_nxt    = rau_pkg::S_DIVN;
      end
      rau_pkg::S_DIVN: begin
        cmd.div_step = 1'b1;
        dc_nxt       = dc_r + 1'b1;
        if (dc_r == KW'(N - 1)) state_nxt = rau_pkg::S_DIVD_INIT;
      end
      rau_pkg::S_DIVD_INIT: begin
        cmd.q_store_num = 1'b1;
        cmd.div_init    = 1'b1;
        cmd.div_den     = 1'b1;
        dc_nxt          = '0;
        state_nxt       = rau_pkg::S_DIVD;
      end
      rau_pkg::S_DIVD: begin
        cmd.div_step = 1'b1;
        dc_nxt       = dc_r + 1'b1;
        if (dc_r == KW'(N - 1)) state_nxt = rau_pkg::S_STORE;
      end
      rau_pkg::S_STORE: begin
        cmd.q_store_den = 1'b1;
        state_nxt       = rau_pkg::S_FIN;
      end
      rau_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = rau_pkg::S_IDLE;
        end
      end
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/rau_dp.sv -----
// rau_dp: operand registers, shared multiplier, binary GCD, restoring divider
// and output register. Depends on rau_pkg.
module rau_dp #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rau_pkg::in_item_t   in_data,
  input  rau_pkg::cmd_t       cmd,
  output rau_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output rau_pkg::out_item_t  out_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int N  = 2 * W + 1;
  localparam int KW = $clog2(N + 1);

  logic [2:0]      func_r;
  logic            an_r, bn_r, neg_r;
  logic [W-1:0]    am_r, bm_r, ad_r, bd_r;
  rau_pkg::kind_t  kind_r;
  logic [2*W-1:0]  p0_r, p1_r, p2_r;
  logic [N-1:0]    n_r, d_r, gx_r, gy_r, g_r, dq_r;
  logic [N:0]      drem_r;
  logic [KW-1:0]   gk_r;
  rau_pkg::out_item_t out_r;
  logic            out_valid_r;

  // operand decode
  logic [W-1:0]   va, vb, ld_am, ld_bm, ld_ad, ld_bd;
  rau_pkg::kind_t ld_kind;

  always_comb begin
    va    = in_data.a_num[W-1:0];
    vb    = in_data.b_num[W-1:0];
    ld_am = va[W-1] ? (~va + 1'b1) : va;
    ld_bm = vb[W-1] ? (~vb + 1'b1) : vb;
    ld_ad = in_data.a_den[W-1:0];
    ld_bd = in_data.b_den[W-1:0];
    if (in_data.func > rau_pkg::FN_HALVE) ld_kind = rau_pkg::RK_ZERO;
    else if (ld_ad == '0 || (in_data.func < rau_pkg::FN_NEG && ld_bd == '0))
      ld_kind = rau_pkg::RK_DIV0;
    else if (in_data.func == rau_pkg::FN_DIV && ld_bm == '0) ld_kind = rau_pkg::RK_DIV0;
    else ld_kind = rau_pkg::RK_NORMAL;
  end

  // shared multiplier
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::MS_AM_B: begin
        mul_a = am_r;
        mul_b = (func_r == rau_pkg::FN_MUL) ? bm_r : bd_r;
      end
      rau_pkg::MS_AD_BM: begin
        mul_a = ad_r;
        mul_b = bm_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // fraction forming
  logic         bneg, f_neg;
  logic [N-1:0] f_num, f_den, e0, e1, e2, eam, ead;

  always_comb begin
    e0    = {1'b0, p0_r};
    e1    = {1'b0, p1_r};
    e2    = {1'b0, p2_r};
    eam   = N'(am_r);
    ead   = N'(ad_r);
    bneg  = bn_r ^ (func_r == rau_pkg::FN_SUB);
    f_num = '0;
    f_den = N'(1);
    f_neg = 1'b0;
    case (func_r) inside
      rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
        f_den = e2;
        if (an_r == bneg) begin
          f_num = e0 + e1;
          f_neg = an_r;
        end else if (e0 >= e1) begin
          f_num = e0 - e1;
          f_neg = an_r;
        end else begin
          f_num = e1 - e0;
          f_neg = bneg;
        end
      end
      rau_pkg::FN_MUL: begin
        f_num = e0;
        f_den = e2;
        f_neg = an_r ^ bn_r;
      end
      rau_pkg::FN_DIV: begin
        f_num = e0;
        f_den = e1;
        f_neg = an_r ^ bn_r;
      end
      rau_pkg::FN_NEG: begin
        f_num = eam;
        f_den = ead;
        f_neg = ~an_r;
      end
      rau_pkg::FN_HALVE: begin
        f_neg = an_r;
        if (!am_r[0]) begin
          f_num = eam >> 1;
          f_den = ead;
        end else begin
          f_num = eam;
          f_den = ead << 1;
        end
      end
      default: ;
    endcase
  end

  // divider step
  logic [N:0] dv_t, dv_g;
  logic       dv_ge;

  always_comb begin
    dv_t  = {drem_r[N-1:0], dq_r[N-1]};
    dv_g  = {1'b0, g_r};
    dv_ge = dv_t >= dv_g;
  end

  // range check and result
  logic               ovf;
  logic [31:0]        mag32;
  rau_pkg::out_item_t res;

  always_comb begin
    ovf = (d_r[N-1:W] != '0) ||
          (neg_r ? (n_r > (N'(1) << (W - 1))) : (n_r[N-1:W-1] != '0));
    mag32 = 32'(n_r[W-1:0]);
    res.res_num = '0;
    res.res_den = 32'd1;
    res.status  = rau_pkg::ST_OK;
    case (kind_r)
      rau_pkg::RK_DIV0: res.status = rau_pkg::ST_DIV0;
      rau_pkg::RK_NORMAL: begin
        if (ovf) res.status = rau_pkg::ST_OVF;
        else begin
          res.res_num = $signed(neg_r ? (~mag32 + 1'b1) : mag32);
          res.res_den = 32'(d_r[W-1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      an_r   <= va[W-1];
      bn_r   <= vb[W-1];
      am_r   <= ld_am;
      bm_r   <= ld_bm;
      ad_r   <= ld_ad;
      bd_r   <= ld_bd;
      kind_r <= ld_kind;
    end else if (cmd.form && f_num == '0) begin
      kind_r <= rau_pkg::RK_ZERO;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rau_pkg::MS_AM_B:  p0_r <= prod;
        rau_pkg::MS_AD_BM: p1_r <= prod;
        default:           p2_r <= prod;
      endcase
    end
    if (cmd.form) begin
      n_r   <= f_num;
      d_r   <= f_den;
      neg_r <= f_neg;
      gx_r  <= f_num;
      gy_r  <= f_den;
      gk_r  <= '0;
    end
    // binary GCD
    if (cmd.gcd_step) begin
      if (sts.gcd_done) g_r <= (gx_r | gy_r) << gk_r;
      else if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gk_r <= gk_r + 1'b1;
      end else if (!gx_r[0]) gx_r <= gx_r >> 1;
      else if (!gy_r[0]) gy_r <= gy_r >> 1;
      else if (gx_r >= gy_r) gx_r <= gx_r - gy_r;
      else gy_r <= gy_r - gx_r;
    end
    if (cmd.div_init) begin
      dq_r   <= cmd.div_den ? d_r : n_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      drem_r <= dv_ge ? (dv_t - dv_g) : dv_t;
      dq_r   <= {dq_r[N-2:0], dv_ge};
    end
    if (cmd.q_store_num) n_r <= dq_r;
    if (cmd.q_store_den) d_r <= dq_r;
    if (cmd.out_load) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_comb begin
    sts.early    = kind_r != rau_pkg::RK_NORMAL;
    sts.use_mul  = func_r < rau_pkg::FN_NEG;
    sts.gcd_done = (gx_r == '0) || (gy_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/rational_arith_unit.sv -----
// rational_arith_unit: top level, joins the controller and the datapath.
// Depends on rau_pkg, rau_ctrl, rau_dp.
//
// One item is worked at a time; in_ready is high only while the unit is idle.
// An arithmetic item forms its products in S_MUL0, S_MUL1 and S_MUL2 on the
// single shared multiplier, then runs a binary GCD and two bit-serial
// divisions that divide numerator and denominator by the GCD; negate and
// halve skip the multiplies. Errors and unused codes go from S_CLASS
// straight to S_FIN, and zero results from S_GCD. The result waits in an
// output register, so the unit returns to idle once the register is free.
module rational_arith_unit #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rau_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rau_pkg::out_item_t  out_data
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/rau_checker.sv -----
// rau_checker: port-level assertions for rational_arith_unit, with its bind.
// Depends on rau_pkg.
module rau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rau_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rau_pkg::ST_OK |->
      out_data.res_num == 0 && out_data.res_den == 32'd1)
    else $error("error result not 0/1");

  a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.res_num == 0 |-> out_data.res_den == 32'd1)
    else $error("zero not shown as 0/1");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.res_den != 32'd0 && out_data.status != 2'd3)
    else $error("bad denominator or status");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
